FILE: hdl/vfc_pkg.sv
//------------------------------------------------------------------------------
// vfc_pkg
// Shared types, constants and tables of the voxel face culler.
//------------------------------------------------------------------------------
package vfc_pkg;

	localparam int SIZE_X      = 16;
	localparam int SIZE_Y      = 16;
	localparam int SIZE_Z      = 16;
	localparam int TILE_TYPES  = 256;
	localparam int STORE_DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int SLOT_W      = $clog2(TILE_TYPES);
	localparam int TILE_CODES  = 256;
	localparam int FACES       = 6;

	typedef logic [3:0]        coord_t;
	typedef logic [7:0]        tile_t;
	typedef logic [2:0]        face_id_t;
	typedef logic [16:0]       vert_t;
	typedef logic [1:0]        cmd_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef slot_t             slot_lut_t [TILE_CODES];

	localparam cmd_t CMD_LOAD     = 2'd0;
	localparam cmd_t CMD_SCAN     = 2'd1;
	localparam cmd_t CMD_NEW_MESH = 2'd2;

	localparam face_id_t FACE_TOP     = 3'd0;
	localparam face_id_t FACE_BOTTOM  = 3'd1;
	localparam face_id_t FACE_MINUS_X = 3'd2;
	localparam face_id_t FACE_PLUS_X  = 3'd3;
	localparam face_id_t FACE_PLUS_Z  = 3'd4;
	localparam face_id_t FACE_MINUS_Z = 3'd5;

	localparam vert_t VERTS_PER_QUAD = 17'd4;

	typedef struct packed {
		cmd_t   cmd;
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
		tile_t  tile_in;
	} item_t;

	typedef struct packed {
		coord_t   face_x;
		coord_t   face_y;
		coord_t   face_z;
		face_id_t face_id;
		tile_t    tile_out;
		vert_t    base_vertex;
		logic     last;
	} face_t;

	function automatic slot_lut_t build_slot_lut();
		slot_lut_t lut;
		for (int i = 0; i < TILE_CODES; i++) begin
			lut[i] = slot_t'(i % TILE_TYPES);
		end
		return lut;
	endfunction

	localparam slot_lut_t SLOT_LUT = build_slot_lut();

	function automatic addr_t voxel_addr(coord_t x, coord_t y, coord_t z);
		logic [31:0] full;
		full = (32'(x) * 32'(SIZE_Y) + 32'(y)) * 32'(SIZE_Z) + 32'(z);
		return addr_t'(full);
	endfunction

	function automatic logic in_chunk(coord_t x, coord_t y, coord_t z);
		return (int'(x) < SIZE_X) && (int'(y) < SIZE_Y) && (int'(z) < SIZE_Z);
	endfunction

endpackage

FILE: hdl/vfc_voxel_ram.sv
//------------------------------------------------------------------------------
// vfc_voxel_ram
// Voxel tile store: one write port, one read port with registered data.
//------------------------------------------------------------------------------
module vfc_voxel_ram (
	input  logic           clk,
	input  logic           we,
	input  vfc_pkg::addr_t waddr,
	input  vfc_pkg::tile_t wdata,
	input  logic           re,
	input  vfc_pkg::addr_t raddr,
	output vfc_pkg::tile_t rdata
);

	vfc_pkg::tile_t mem [vfc_pkg::STORE_DEPTH];
	vfc_pkg::tile_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/vfc_counter_ram.sv
//------------------------------------------------------------------------------
// vfc_counter_ram
// Per-type vertex counters with valid bits; an invalid entry reads as zero.
//------------------------------------------------------------------------------
module vfc_counter_ram (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clr,
	input  logic           we,
	input  vfc_pkg::slot_t waddr,
	input  vfc_pkg::vert_t wdata,
	input  logic           re,
	input  vfc_pkg::slot_t raddr,
	output vfc_pkg::vert_t rdata
);

	vfc_pkg::vert_t                  mem [vfc_pkg::TILE_TYPES];
	logic [vfc_pkg::TILE_TYPES-1:0]  valid_q;
	vfc_pkg::vert_t                  rdata_q;
	logic                            rvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q  <= mem[raddr];
			rvalid_q <= valid_q[raddr];
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

FILE: hdl/voxel_face_culler.sv
//------------------------------------------------------------------------------
// voxel_face_culler
// Keeps a chunk of voxel tile codes and emits one record per exposed face.
//------------------------------------------------------------------------------
// usage
//   item channel (item_valid/item_ready/item): load writes one voxel, scan
//   names a voxel to cull, new mesh zeroes all per-type vertex counters.
//   face channel (face_valid/face_ready/face): one record per exposed face
//   of a scanned solid voxel, top, bottom, -x, +x, +z, -z, last on the final.
//   cfg_wr_en/cfg_wr_data write the empty tile code; only while idle.
// timing
//   load and new mesh are done on the transfer and leave the block idle. a scan
//   reads the voxel and its six neighbors through the single read port of the
//   voxel memory, then reads the type counter (S_READ, S_LAST, S_CNT); then
//   S_EMIT loads one record per cycle while face_ready is high. a scan of an
//   empty voxel ends with the counter read.
//   item_ready returns the cycle after the last record is loaded.
// reset
//   all counters read as zero, empty code is 0, voxel memory is not cleared.
// stall
//   a record waits in the output register while face_ready is low and the
//   scan holds with it; item_ready stays low until the last record is loaded
//------------------------------------------------------------------------------
module voxel_face_culler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  vfc_pkg::tile_t cfg_wr_data,
	input  logic           item_valid,
	output logic           item_ready,
	input  vfc_pkg::item_t item,
	output logic           face_valid,
	input  logic           face_ready,
	output vfc_pkg::face_t face
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_LAST = 3'd2;
	localparam logic [2:0] S_CNT  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]                   state_q;
	vfc_pkg::face_id_t            rd_face_q;
	vfc_pkg::tile_t               empty_q;
	vfc_pkg::coord_t              pos_x_q, pos_y_q, pos_z_q;
	vfc_pkg::tile_t               tile_q;
	logic [vfc_pkg::FACES-1:0]    exp_q;
	vfc_pkg::slot_t               slot_q;
	vfc_pkg::vert_t               cnt_q;
	vfc_pkg::face_t               face_q;
	logic                         face_valid_q;

	logic                         acc;
	logic                         inside_in;
	vfc_pkg::addr_t               in_addr;
	vfc_pkg::coord_t              nx, ny, nz;
	logic [vfc_pkg::FACES-1:0]    border;
	vfc_pkg::face_id_t            prev_face;
	logic                         vox_re;
	vfc_pkg::addr_t               vox_raddr;
	vfc_pkg::tile_t               vox_rdata;
	logic                         nb_open;
	vfc_pkg::slot_t               slot_rd;
	vfc_pkg::vert_t               cnt_rdata;
	logic [vfc_pkg::FACES-1:0]    pick;
	vfc_pkg::face_id_t            sel_id;
	logic                         is_last;
	logic                         load;

	assign item_ready = (state_q == S_IDLE);
	assign acc        = item_valid && item_ready;
	assign inside_in  = vfc_pkg::in_chunk(item.pos_x, item.pos_y, item.pos_z);
	assign in_addr    = vfc_pkg::voxel_addr(item.pos_x, item.pos_y, item.pos_z);

	// neighbor of the face being read
	always_comb begin
		nx = pos_x_q;
		ny = pos_y_q;
		nz = pos_z_q;
		unique case (rd_face_q)
			vfc_pkg::FACE_TOP:     ny = pos_y_q + 4'd1;
			vfc_pkg::FACE_BOTTOM:  ny = pos_y_q - 4'd1;
			vfc_pkg::FACE_MINUS_X: nx = pos_x_q - 4'd1;
			vfc_pkg::FACE_PLUS_X:  nx = pos_x_q + 4'd1;
			vfc_pkg::FACE_PLUS_Z:  nz = pos_z_q + 4'd1;
			vfc_pkg::FACE_MINUS_Z: nz = pos_z_q - 4'd1;
			default: ;
		endcase
	end

	always_comb begin
		border = '0;
		border[vfc_pkg::FACE_TOP]     = (pos_y_q == vfc_pkg::coord_t'(vfc_pkg::SIZE_Y - 1));
		border[vfc_pkg::FACE_BOTTOM]  = (pos_y_q == '0);
		border[vfc_pkg::FACE_MINUS_X] = (pos_x_q == '0);
		border[vfc_pkg::FACE_PLUS_X]  = (pos_x_q == vfc_pkg::coord_t'(vfc_pkg::SIZE_X - 1));
		border[vfc_pkg::FACE_PLUS_Z]  = (pos_z_q == vfc_pkg::coord_t'(vfc_pkg::SIZE_Z - 1));
		border[vfc_pkg::FACE_MINUS_Z] = (pos_z_q == '0);
	end

	assign prev_face = rd_face_q - 3'd1;
	assign vox_re    = (acc && item.cmd == vfc_pkg::CMD_SCAN && inside_in) ||
	                   (state_q == S_READ);
	assign vox_raddr = (state_q == S_READ) ? vfc_pkg::voxel_addr(nx, ny, nz) : in_addr;
	assign nb_open   = (vox_rdata == empty_q);
	assign slot_rd   = vfc_pkg::SLOT_LUT[tile_q];

	vfc_voxel_ram u_voxel_ram (
		.clk   (clk),
		.we    (acc && item.cmd == vfc_pkg::CMD_LOAD && inside_in),
		.waddr (in_addr),
		.wdata (item.tile_in),
		.re    (vox_re),
		.raddr (vox_raddr),
		.rdata (vox_rdata)
	);

	// lowest remaining face
	always_comb begin
		pick   = exp_q & (~exp_q + 6'd1);
		sel_id = vfc_pkg::FACE_TOP;
		for (int i = vfc_pkg::FACES - 1; i >= 0; i--) begin
			if (exp_q[i]) begin
				sel_id = vfc_pkg::face_id_t'(i);
			end
		end
		is_last = ((exp_q & ~pick) == '0);
	end

	assign load = (state_q == S_EMIT) && (!face_valid_q || face_ready);

	vfc_counter_ram u_counter_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (acc && item.cmd == vfc_pkg::CMD_NEW_MESH),
		.we     (load && is_last),
		.waddr  (slot_q),
		.wdata  (cnt_q + vfc_pkg::VERTS_PER_QUAD),
		.re     (state_q == S_LAST),
		.raddr  (slot_rd),
		.rdata  (cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rd_face_q    <= vfc_pkg::FACE_TOP;
			empty_q      <= '0;
			face_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				empty_q <= cfg_wr_data;
			end
			if (load) begin
				face_valid_q <= 1'b1;
			end else if (face_ready) begin
				face_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc && item.cmd == vfc_pkg::CMD_SCAN && inside_in) begin
						rd_face_q <= vfc_pkg::FACE_TOP;
						state_q   <= S_READ;
					end
				end
				S_READ: begin
					rd_face_q <= rd_face_q + 3'd1;
					if (rd_face_q == vfc_pkg::FACE_MINUS_Z) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= (tile_q == empty_q) ? S_IDLE : S_CNT;
				end
				S_CNT: begin
					state_q <= (exp_q == '0) ? S_IDLE : S_EMIT;
				end
				S_EMIT: begin
					if (load && is_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pos_x_q <= item.pos_x;
			pos_y_q <= item.pos_y;
			pos_z_q <= item.pos_z;
		end
		if (state_q == S_READ) begin
			if (rd_face_q == vfc_pkg::FACE_TOP) begin
				tile_q <= vox_rdata;
			end else begin
				exp_q[prev_face] <= border[prev_face] || nb_open;
			end
		end
		if (state_q == S_LAST) begin
			exp_q[vfc_pkg::FACE_MINUS_Z] <= border[vfc_pkg::FACE_MINUS_Z] || nb_open;
			slot_q <= slot_rd;
		end
		if (state_q == S_CNT) begin
			cnt_q <= cnt_rdata;
		end
		if (load) begin
			face_q.face_x      <= pos_x_q;
			face_q.face_y      <= pos_y_q;
			face_q.face_z      <= pos_z_q;
			face_q.face_id     <= sel_id;
			face_q.tile_out    <= tile_q;
			face_q.base_vertex <= cnt_q;
			face_q.last        <= is_last;
			cnt_q              <= cnt_q + vfc_pkg::VERTS_PER_QUAD;
			exp_q              <= exp_q & ~pick;
		end
	end

	assign face_valid = face_valid_q;
	assign face       = face_q;

endmodule

FILE: hdl/vfc_checker.sv
//------------------------------------------------------------------------------
// vfc_checker
// Port-level checks of the voxel face culler, bound to the top level.
//------------------------------------------------------------------------------
module vfc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           item_valid,
	input logic           item_ready,
	input vfc_pkg::item_t item,
	input logic           face_valid,
	input logic           face_ready,
	input vfc_pkg::face_t face
);

	// stalled record holds
	a_face_hold: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid && !face_ready |=> face_valid && $stable(face))
		else $error("face record changed while stalled");

	// records are only loaded while a scan is in flight
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(face_valid) |-> $past(!item_ready))
		else $error("face record appeared while idle");

	// a scan in the chunk keeps the item side busy
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.cmd == vfc_pkg::CMD_SCAN &&
		vfc_pkg::in_chunk(item.pos_x, item.pos_y, item.pos_z) |=> !item_ready)
		else $error("scan transfer did not stall the item channel");

	a_face_id: assert property (@(posedge clk) disable iff (!arst_n)
		face_valid |-> face.face_id <= vfc_pkg::FACE_MINUS_Z)
		else $error("face id out of range");

endmodule

bind voxel_face_culler vfc_checker u_vfc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_ready (item_ready),
	.item       (item),
	.face_valid (face_valid),
	.face_ready (face_ready),
	.face       (face)
);

FILE: sim/vfc_face_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// vfc_face_checker
// Watches the item and face channels of the voxel face culler, keeps its own
// chunk image, vertex counters and empty code, works out the face records each
// scan should produce and compares every face transfer against the oldest one.
//------------------------------------------------------------------------------
module vfc_face_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  vfc_pkg::tile_t cfg_wr_data,
	input  logic           item_valid,
	input  logic           item_ready,
	input  vfc_pkg::item_t item,
	input  logic           face_valid,
	input  logic           face_ready,
	input  vfc_pkg::face_t face,
	output int             fail_count,
	output int             faces_pending
);
	import vfc_pkg::*;

	tile_t vox_map [SIZE_X][SIZE_Y][SIZE_Z];
	vert_t vert_count [TILE_TYPES];
	tile_t empty_tile;
	face_t faces_due [$];

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic cull_voxel(input coord_t x, input coord_t y, input coord_t z);
		logic  open_face [FACES];
		tile_t tile;
		int    slot;
		int    total;
		int    emitted;
		face_t rec;
		if (!((int'(x) < SIZE_X) && (int'(y) < SIZE_Y) && (int'(z) < SIZE_Z)))
			return;
		tile = vox_map[x][y][z];
		if (tile == empty_tile)
			return;
		open_face[FACE_TOP]     = (y == SIZE_Y - 1) || (vox_map[x][y + 1][z] == empty_tile);
		open_face[FACE_BOTTOM]  = (y == 0) || (vox_map[x][y - 1][z] == empty_tile);
		open_face[FACE_MINUS_X] = (x == 0) || (vox_map[x - 1][y][z] == empty_tile);
		open_face[FACE_PLUS_X]  = (x == SIZE_X - 1) || (vox_map[x + 1][y][z] == empty_tile);
		open_face[FACE_PLUS_Z]  = (z == SIZE_Z - 1) || (vox_map[x][y][z + 1] == empty_tile);
		open_face[FACE_MINUS_Z] = (z == 0) || (vox_map[x][y][z - 1] == empty_tile);
		slot = int'(tile) % TILE_TYPES;
		total = 0;
		for (int f = 0; f < FACES; f++) begin
			if (open_face[f])
				total++;
		end
		emitted = 0;
		for (int f = 0; f < FACES; f++) begin
			if (open_face[f]) begin
				emitted++;
				rec.face_x      = x;
				rec.face_y      = y;
				rec.face_z      = z;
				rec.face_id     = face_id_t'(f);
				rec.tile_out    = tile;
				rec.base_vertex = vert_count[slot];
				rec.last        = (emitted == total);
				vert_count[slot] = vert_count[slot] + VERTS_PER_QUAD;
				faces_due = {faces_due, rec};
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		face_t want;
		if (!arst_n) begin
			for (int i = 0; i < TILE_TYPES; i++)
				vert_count[i] = '0;
			empty_tile = '0;
			faces_due.delete();
		end else begin
			if (face_valid && face_ready) begin
				if (faces_due.size() == 0) begin
					$error("face transfer with none expected: face_id %0d at %0d,%0d,%0d",
						face.face_id, face.face_x, face.face_y, face.face_z);
					fail_count++;
				end else begin
					want = faces_due.pop_front();
					check_field("face_x", want.face_x, face.face_x);
					check_field("face_y", want.face_y, face.face_y);
					check_field("face_z", want.face_z, face.face_z);
					check_field("face_id", want.face_id, face.face_id);
					check_field("tile_out", want.tile_out, face.tile_out);
					check_field("base_vertex", want.base_vertex, face.base_vertex);
					check_field("last", want.last, face.last);
				end
			end
			if (item_valid && item_ready) begin
				case (item.cmd)
					CMD_LOAD: begin
						if ((int'(item.pos_x) < SIZE_X) && (int'(item.pos_y) < SIZE_Y) &&
								(int'(item.pos_z) < SIZE_Z))
							vox_map[item.pos_x][item.pos_y][item.pos_z] = item.tile_in;
					end
					CMD_SCAN: begin
						cull_voxel(item.pos_x, item.pos_y, item.pos_z);
					end
					CMD_NEW_MESH: begin
						for (int i = 0; i < TILE_TYPES; i++)
							vert_count[i] = '0;
					end
					default: ;
				endcase
			end
			if (cfg_wr_en)
				empty_tile = cfg_wr_data;
		end
		faces_pending = faces_due.size();
	end

endmodule

FILE: sim/voxel_face_culler_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// voxel_face_culler_tb
// Drives load, scan and new-mesh items into the voxel face culler with random
// gaps on both channels, changes the empty code between phases and leaves all
// checking of face records to vfc_face_checker. Covers a directed set of
// corner and hidden-face cases, a back-to-back scan run and random box phases.
//------------------------------------------------------------------------------
module voxel_face_culler_tb;
	import vfc_pkg::*;

	localparam cmd_t CMD_UNUSED   = 2'd3;
	localparam int   LONG_HOLD    = 300;
	localparam int   SETTLE       = 20;
	localparam int   BURST_SCANS  = 40;
	localparam int   RANDOM_ITEMS = 350;
	localparam int   PHASE_ITEMS  = 30;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cfg_wr_en;
	tile_t cfg_wr_data;
	logic  item_valid;
	logic  item_ready;
	item_t item;
	logic  face_valid;
	logic  face_ready;
	face_t face;
	int    fail_count;
	int    faces_pending;

	bit    gaps_on;
	bit    stalls_on;
	bit    rx_hold_req;
	tile_t empty_now;
	bit    written [SIZE_X][SIZE_Y][SIZE_Z];
	int    items_sent;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	voxel_face_culler i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.face_valid (face_valid),
		.face_ready (face_ready),
		.face       (face)
	);

	vfc_face_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.face_valid   (face_valid),
		.face_ready   (face_ready),
		.face         (face),
		.fail_count   (fail_count),
		.faces_pending(faces_pending)
	);

	function automatic item_t make_item(cmd_t c, int x, int y, int z, int t);
		item_t it;
		it.cmd     = c;
		it.pos_x   = coord_t'(x);
		it.pos_y   = coord_t'(y);
		it.pos_z   = coord_t'(z);
		it.tile_in = tile_t'(t);
		return it;
	endfunction

	function automatic bit scannable(int x, int y, int z);
		if (!written[x][y][z])
			return 1'b0;
		if (x > 0 && !written[x - 1][y][z])
			return 1'b0;
		if (x < SIZE_X - 1 && !written[x + 1][y][z])
			return 1'b0;
		if (y > 0 && !written[x][y - 1][z])
			return 1'b0;
		if (y < SIZE_Y - 1 && !written[x][y + 1][z])
			return 1'b0;
		if (z > 0 && !written[x][y][z - 1])
			return 1'b0;
		if (z < SIZE_Z - 1 && !written[x][y][z + 1])
			return 1'b0;
		return 1'b1;
	endfunction

	// mostly the empty code and a few shared types so counters climb
	function automatic int pick_tile();
		int r;
		r = $urandom_range(9, 0);
		case (r)
			0, 1, 2: return int'(empty_now);
			3:       return 1;
			4:       return 2;
			5:       return 128;
			6:       return 255;
			7:       return 0;
			default: return $urandom_range(255, 0);
		endcase
	endfunction

	function automatic int pick_corner(int size, int span);
		int r;
		r = $urandom_range(2, 0);
		if (r == 0)
			return 0;
		if (r == 1)
			return size - span;
		return $urandom_range(size - span, 0);
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		gap = gaps_on ? $urandom_range(15, 0) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		if (it.cmd != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic load_voxel(input int x, input int y, input int z, input int t);
		send_item(make_item(CMD_LOAD, x, y, z, t));
		written[x][y][z] = 1'b1;
	endtask

	task automatic scan_voxel(input int x, input int y, input int z);
		send_item(make_item(CMD_SCAN, x, y, z, $urandom_range(255, 0)));
	endtask

	task automatic new_mesh();
		send_item(make_item(CMD_NEW_MESH, $urandom_range(15, 0), $urandom_range(15, 0),
			$urandom_range(15, 0), $urandom_range(255, 0)));
	endtask

	task automatic load_cross(input int x, input int y, input int z, input int center,
			input int around);
		load_voxel(x, y, z, center);
		load_voxel(x, y + 1, z, around);
		load_voxel(x, y - 1, z, around);
		load_voxel(x - 1, y, z, around);
		load_voxel(x + 1, y, z, around);
		load_voxel(x, y, z + 1, around);
		load_voxel(x, y, z - 1, around);
	endtask

	// hold the input until every face has drained and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (faces_pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_empty(input tile_t code);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= code;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		empty_now = code;
	endtask

	task automatic run_phase(input int p);
		int dx, dy, dz, x0, y0, z0, x, y, z, r, spot;
		int spots [$];
		dx = $urandom_range(4, 3);
		dy = $urandom_range(4, 3);
		dz = $urandom_range(4, 3);
		x0 = pick_corner(SIZE_X, dx);
		y0 = pick_corner(SIZE_Y, dy);
		z0 = pick_corner(SIZE_Z, dz);
		for (int i = 0; i < dx; i++)
			for (int j = 0; j < dy; j++)
				for (int k = 0; k < dz; k++)
					load_voxel(x0 + i, y0 + j, z0 + k, pick_tile());
		for (int i = 0; i < dx; i++)
			for (int j = 0; j < dy; j++)
				for (int k = 0; k < dz; k++)
					if (scannable(x0 + i, y0 + j, z0 + k))
						spots = {spots, ((x0 + i) * SIZE_Y + y0 + j) * SIZE_Z + z0 + k};
		if (p == 2) begin
			gaps_on = 1'b0;
			rx_hold_req = 1'b1;
		end
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			r = $urandom_range(99, 0);
			if (r < 50 && spots.size() > 0) begin
				spot = spots[$urandom_range(spots.size() - 1, 0)];
				x = spot / (SIZE_Y * SIZE_Z);
				y = (spot / SIZE_Z) % SIZE_Y;
				z = spot % SIZE_Z;
				scan_voxel(x, y, z);
			end else if (r < 80) begin
				load_voxel(x0 + $urandom_range(dx - 1, 0), y0 + $urandom_range(dy - 1, 0),
					z0 + $urandom_range(dz - 1, 0), pick_tile());
			end else if (r < 87) begin
				new_mesh();
			end else if (r < 95) begin
				load_voxel($urandom_range(SIZE_X - 1, 0), $urandom_range(SIZE_Y - 1, 0),
					$urandom_range(SIZE_Z - 1, 0), $urandom_range(255, 0));
			end else begin
				send_item(make_item(CMD_UNUSED, $urandom_range(15, 0), $urandom_range(15, 0),
					$urandom_range(15, 0), $urandom_range(255, 0)));
			end
		end
	endtask

	initial begin : face_sink
		int wait_cycles;
		face_ready = 1'b0;
		forever begin
			if (rx_hold_req) begin
				wait_cycles = LONG_HOLD;
				rx_hold_req = 1'b0;
			end else begin
				wait_cycles = stalls_on ? $urandom_range(15, 0) : 0;
			end
			@(negedge clk);
			if (wait_cycles > 0) begin
				face_ready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			face_ready <= 1'b1;
			@(posedge clk);
			while (!face_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int target;
		int p;
		int w;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		item_valid = 1'b0;
		item = '0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		rx_hold_req = 1'b0;
		empty_now = '0;
		items_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_empty(8'd0);

		// corner at the origin, one side covered
		load_voxel(0, 0, 0, 5);
		load_voxel(1, 0, 0, 0);
		load_voxel(0, 1, 0, 5);
		load_voxel(0, 0, 1, 0);
		scan_voxel(0, 0, 0);
		// far corner, two sides covered, scanned twice
		load_voxel(15, 15, 15, 255);
		load_voxel(14, 15, 15, 255);
		load_voxel(15, 14, 15, 0);
		load_voxel(15, 15, 14, 3);
		scan_voxel(15, 15, 15);
		scan_voxel(15, 15, 15);
		send_item(make_item(CMD_UNUSED, 15, 15, 15, 255));
		new_mesh();
		scan_voxel(0, 0, 0);
		// empty voxel gives nothing
		load_voxel(0, 0, 0, 0);
		scan_voxel(0, 0, 0);
		// solid voxel fully enclosed
		load_cross(8, 8, 8, 9, 9);
		scan_voxel(8, 8, 8);

		// back-to-back scans with no idling on either side
		settle();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		new_mesh();
		load_cross(8, 8, 8, 200, 0);
		repeat (BURST_SCANS) scan_voxel(8, 8, 8);

		target = items_sent + RANDOM_ITEMS;
		p = 0;
		while (items_sent < target) begin
			settle();
			if (p == 0)
				write_empty(8'd255);
			else if (p == 1)
				write_empty(8'd0);
			else
				write_empty(tile_t'($urandom_range(255, 0)));
			gaps_on = ($urandom_range(3, 0) != 0);
			stalls_on = ($urandom_range(3, 0) != 0);
			if (p == 4) begin
				gaps_on = 1'b0;
				stalls_on = 1'b0;
			end
			run_phase(p);
			p++;
		end

		@(negedge clk);
		item_valid <= 1'b0;
		for (w = 0; w < 5000 && faces_pending != 0; w++) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (faces_pending != 0)
			$error("%0d expected face records never arrived", faces_pending);
		if (fail_count == 0 && faces_pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
